>>> hdl/llrr_pkg.sv
package llrr_pkg;

	localparam int LINK_W = 11;

	typedef logic [LINK_W-1:0] link_t;

	localparam logic OP_INIT   = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// configuration register map
	localparam int    APB_ADDR_W      = 3;
	localparam int    APB_DATA_W      = 32;
	localparam logic  REG_SEL_COUNT   = 1'b0;
	localparam link_t COUNT_RESET     = 11'd1024;

	typedef struct packed {
		logic rd_en;       // capture both link reads for a remove request
		logic commit;      // write back the splice and load the result
		logic init_start;  // load the walk counter and limit
		logic init_step;   // write one position's links
	} cmd_t;

	typedef struct packed {
		logic out_stall;   // result register full and not taken
		logic init_none;   // walk has nothing to write
		logic init_last;   // current walk position is the final one
	} status_t;

endpackage

>>> hdl/llrr_if.sv
interface llrr_req_if import llrr_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  opcode;
	link_t span_first;
	link_t span_last;

	modport source (output valid, opcode, span_first, span_last, input ready);
	modport sink (input valid, opcode, span_first, span_last, output ready);
endinterface

interface llrr_rsp_if import llrr_pkg::*; ();
	logic  valid;
	logic  ready;
	link_t left_neighbor;
	link_t right_neighbor;

	modport source (output valid, left_neighbor, right_neighbor, input ready);
	modport sink (input valid, left_neighbor, right_neighbor, output ready);
endinterface

>>> hdl/llrr_cfg.sv
module llrr_cfg import llrr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output link_t                 count
);

	link_t count_q;
	logic  sel_count;

	// word index sits above the byte offset
	assign sel_count = (paddr[APB_ADDR_W-1] == REG_SEL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && sel_count) begin
			count_q <= pwdata[LINK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_count) begin
			prdata = {{(APB_DATA_W-LINK_W){1'b0}}, count_q};
		end
	end

	assign pready = 1'b1;
	assign count  = count_q;

endmodule

>>> hdl/llrr_ctrl.sv
module llrr_ctrl import llrr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_opcode,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REMOVE = 2'd1;
	localparam logic [1:0] ST_INIT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == OP_REMOVE) begin
						cmd.rd_en = 1'b1;
						state_d   = ST_REMOVE;
					end else begin
						cmd.init_start = 1'b1;
						state_d        = ST_INIT;
					end
				end
			end
			ST_REMOVE: begin
				if (!status.out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_INIT: begin
				if (status.init_none) begin
					state_d = ST_IDLE;
				end else begin
					cmd.init_step = 1'b1;
					if (status.init_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/llrr_datapath.sv
module llrr_datapath import llrr_pkg::*; #(
	parameter int MAX_COUNT = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t status,
	input  link_t   span_first,
	input  link_t   span_last,
	input  link_t   count,
	input  logic    out_ready,
	output logic    out_valid,
	output link_t   left_neighbor,
	output link_t   right_neighbor
);

	// link values never exceed the field width, so deeper entries are unreachable
	localparam int LINK_MAX = (1 << LINK_W) - 1;
	localparam int LIM      = (MAX_COUNT < LINK_MAX) ? MAX_COUNT : LINK_MAX;
	localparam int DEPTH    = LIM + 1;
	localparam int AW       = $clog2(DEPTH);
	localparam link_t LIM_L = LINK_W'(LIM);

	link_t left_mem  [DEPTH];
	link_t right_mem [DEPTH];

	link_t lft_raw_q, rgt_raw_q;
	logic  lft_ok_q, rgt_ok_q;
	link_t lft, rgt;

	link_t walk_q, limit_q;
	link_t out_left_q, out_right_q;
	logic  out_valid_q;

	logic          l_we, r_we;
	logic [AW-1:0] l_wa, r_wa;
	link_t         l_wd, r_wd;

	// reads of positions above the store give none
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			lft_raw_q <= left_mem[AW'(span_first)];
			rgt_raw_q <= right_mem[AW'(span_last)];
			lft_ok_q  <= (span_first <= LIM_L);
			rgt_ok_q  <= (span_last <= LIM_L);
		end
	end

	assign lft = lft_ok_q ? lft_raw_q : '0;
	assign rgt = rgt_ok_q ? rgt_raw_q : '0;

	always_comb begin
		l_we = 1'b0;
		r_we = 1'b0;
		l_wa = AW'(walk_q);
		r_wa = AW'(walk_q);
		l_wd = walk_q - 1'b1;
		r_wd = (walk_q == limit_q) ? '0 : walk_q + 1'b1;
		if (cmd.init_step) begin
			l_we = 1'b1;
			r_we = 1'b1;
		end else if (cmd.commit) begin
			l_we = (rgt != '0) && (rgt <= LIM_L);
			r_we = (lft != '0) && (lft <= LIM_L);
			l_wa = AW'(rgt);
			r_wa = AW'(lft);
			l_wd = lft;
			r_wd = rgt;
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			left_mem[l_wa] <= l_wd;
		end
		if (r_we) begin
			right_mem[r_wa] <= r_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_start) begin
			walk_q  <= 11'd1;
			limit_q <= (count > LIM_L) ? LIM_L : count;
		end else if (cmd.init_step) begin
			walk_q <= walk_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_left_q  <= lft;
			out_right_q <= rgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_stall = out_valid_q && !out_ready;
	assign status.init_none = (limit_q == '0);
	assign status.init_last = (walk_q == limit_q);

	assign out_valid      = out_valid_q;
	assign left_neighbor  = out_left_q;
	assign right_neighbor = out_right_q;

endmodule

>>> hdl/linked_list_range_remove.sv
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | opcode, span_first, span_last
// rsp     | out | valid/ready   | left_neighbor, right_neighbor
// apb     | in  | psel/penable  | paddr, pwdata, prdata (position_count at 0x0)
//
// Remove: a registered read of both link stores, then the splice write-back
// that also loads the result register.
// Init: min(position_count, MAX_COUNT) positions, one position per cycle
// through the store write ports; it gives no result.
// A full result register holds the remove in its write-back cycle until taken.
// Reset clears control only; link stores hold garbage until init runs.
module linked_list_range_remove import llrr_pkg::*; #(
	parameter int MAX_COUNT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	llrr_req_if.sink              req,
	llrr_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cmd_t    cmd;
	status_t status;
	link_t   count;

	llrr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.count   (count)
	);

	llrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	llrr_datapath #(
		.MAX_COUNT (MAX_COUNT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.span_first     (req.span_first),
		.span_last      (req.span_last),
		.count          (count),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.left_neighbor  (rsp.left_neighbor),
		.right_neighbor (rsp.right_neighbor)
	);

`ifndef NO_ASSERTIONS
	// a commit must never overwrite a result that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(rsp.valid && !rsp.ready))
		else $error("result register overrun");

	// init walk and remove write-back share the store write ports
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.init_step))
		else $error("init and remove write in the same cycle");

	// no new request while a remove read is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> !req.ready)
		else $error("request accepted during a remove");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
	import llrr_pkg::*;

	localparam int MAX_COUNT   = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	// an init request walks up to MAX_COUNT positions and gives no result
	localparam int INIT_DRAIN  = MAX_COUNT + 64;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 600;
	localparam logic [APB_ADDR_W-1:0] ADDR_COUNT = APB_ADDR_W'(4 * REG_SEL_COUNT);

	typedef struct packed {
		logic  opcode;
		link_t first;
		link_t last;
	} span_req_t;

	typedef struct packed {
		link_t left;
		link_t right;
	} neighbors_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	llrr_req_if req_ch();
	llrr_rsp_if rsp_ch();

	linked_list_range_remove #(.MAX_COUNT(MAX_COUNT)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	span_req_t   pending_q[$];
	neighbors_t  neighbor_q[$];
	link_t       left_link[0:MAX_COUNT];
	link_t       right_link[0:MAX_COUNT];
	int unsigned list_count;
	int unsigned written_top;   // positions 1..written_top hold links in both stores
	int unsigned alive_q[$];    // planned live positions, in list order
	int unsigned errors;
	int unsigned cycles;
	int unsigned results_seen;
	logic        req_acc;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned hold_left;
	logic        held_once;
	logic [15:0] ready_pat;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void predict_neighbors(span_req_t r);
		int unsigned n;
		link_t       lft;
		link_t       rgt;
		if (r.opcode == OP_INIT) begin
			n = (list_count > MAX_COUNT) ? MAX_COUNT : list_count;
			for (int unsigned i = 1; i <= n; i++) begin
				left_link[i]  = link_t'(i - 1);
				right_link[i] = (i == n) ? '0 : link_t'(i + 1);
			end
		end else begin
			lft = (r.first > MAX_COUNT) ? '0 : left_link[r.first];
			rgt = (r.last > MAX_COUNT) ? '0 : right_link[r.last];
			neighbor_q.push_back('{lft, rgt});
			if (rgt != 0 && rgt <= MAX_COUNT)
				left_link[rgt] = lft;
			if (lft != 0 && lft <= MAX_COUNT)
				right_link[lft] = rgt;
		end
	endfunction

	task automatic plan_request(logic op, int unsigned first, int unsigned last);
		int unsigned n;
		pending_q.push_back('{op, link_t'(first), link_t'(last)});
		if (op == OP_INIT) begin
			n = (list_count > MAX_COUNT) ? MAX_COUNT : list_count;
			alive_q.delete();
			for (int unsigned i = 1; i <= n; i++)
				alive_q.push_back(i);
			if (n > written_top)
				written_top = n;
		end else begin
			for (int i = alive_q.size() - 1; i >= 0; i--)
				if (alive_q[i] >= first && alive_q[i] <= last)
					alive_q.delete(i);
		end
	endtask

	// mostly well-formed spans over the live list, some broken spans and re-inits
	task automatic plan_random(int unsigned items);
		int unsigned a;
		int unsigned b;
		int unsigned pick;
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (alive_q.size() == 0 && (written_top == 0 || pick < 75)) begin
				plan_request(OP_INIT, $urandom_range(1, MAX_COUNT), $urandom_range(1, MAX_COUNT));
			end else if (alive_q.size() == 0 || pick < 7) begin
				plan_request(OP_REMOVE, $urandom_range(1, written_top),
					$urandom_range(1, written_top));
			end else if (pick < 11) begin
				plan_request(OP_INIT, $urandom_range(1, MAX_COUNT), $urandom_range(1, MAX_COUNT));
			end else begin
				a = $urandom_range(0, alive_q.size() - 1);
				b = a + ((pick < 20) ? $urandom_range(0, 40) : $urandom_range(0, 3));
				if (b >= alive_q.size())
					b = alive_q.size() - 1;
				plan_request(OP_REMOVE, alive_q[a], alive_q[b]);
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || neighbor_q.size() != 0)
			@(posedge clk);
		repeat (INIT_DRAIN) @(posedge clk);
	endtask

	task automatic write_count(int unsigned value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_COUNT;
		pwdata  = APB_DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		list_count = 32'(link_t'(value));
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(link_t'(value))) begin
			$display("%0t: position_count readback expected %0d actual %0d",
				$time, link_t'(value), prdata);
			errors++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	initial begin
		int unsigned phase_counts[9];
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_INIT;
		req_ch.span_first = '0;
		req_ch.span_last  = '0;
		rsp_ch.ready      = 1'b0;
		req_acc           = 1'b0;
		burst_left        = 0;
		gap_left          = 0;
		hold_left         = 0;
		held_once         = 1'b0;
		ready_pat         = 16'hFFFF;
		list_count        = 32'(COUNT_RESET);
		written_top       = 0;
		errors            = 0;
		cycles            = 0;
		results_seen      = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset count: ends of the list, interior spans, reversed and dead spans
		plan_request(OP_INIT, 1, 1);
		plan_request(OP_REMOVE, 1, 1);
		plan_request(OP_REMOVE, MAX_COUNT, MAX_COUNT);
		plan_request(OP_REMOVE, 512, 512);
		plan_request(OP_REMOVE, 500, 600);
		plan_request(OP_REMOVE, 700, 650);
		plan_request(OP_REMOVE, 1, 3);
		plan_request(OP_REMOVE, 2, MAX_COUNT - 1);
		wait_idle();

		// short list; positions past the count keep stale links
		write_count(5);
		plan_request(OP_INIT, MAX_COUNT, MAX_COUNT);
		plan_request(OP_REMOVE, 2, 4);
		plan_request(OP_REMOVE, 8, 9);
		plan_request(OP_REMOVE, 1, 5);
		wait_idle();

		// zero count: init touches nothing
		write_count(0);
		plan_request(OP_INIT, 1, 1);
		plan_request(OP_REMOVE, 3, 3);
		wait_idle();

		// count above the store size is clamped
		write_count(2047);
		plan_request(OP_INIT, 1, 1);
		plan_request(OP_REMOVE, MAX_COUNT - 1, MAX_COUNT);
		plan_request(OP_REMOVE, 1, MAX_COUNT - 2);
		wait_idle();

		write_count(1);
		plan_request(OP_INIT, 1, 1);
		plan_request(OP_REMOVE, 1, 1);

		phase_counts = '{1024, 1, 2, 2047, 64, $urandom_range(1, MAX_COUNT), 1024,
			$urandom_range(2, 300), 3};
		foreach (phase_counts[k]) begin
			wait_idle();
			write_count(phase_counts[k]);
			plan_request(OP_INIT, $urandom_range(1, MAX_COUNT), $urandom_range(1, MAX_COUNT));
			plan_random(PHASE_ITEMS);
		end
		wait_idle();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// request side: bursts with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_acc)
				pending_q.delete(0);
			if (req_ch.valid && !req_acc) begin
				// request still waiting for ready
			end else if (gap_left != 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				req_ch.valid      <= 1'b1;
				req_ch.opcode     <= pending_q[0].opcode;
				req_ch.span_first <= pending_q[0].first;
				req_ch.span_last  <= pending_q[0].last;
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		req_acc = arst_n && req_ch.valid && req_ch.ready;
		if (req_acc)
			predict_neighbors('{req_ch.opcode, req_ch.span_first, req_ch.span_last});
	end

	// result side: rotating stall pattern, plus one long hold to back up the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && results_seen >= HOLD_AFTER && pending_q.size() > 4) begin
				held_once    <= 1'b1;
				hold_left    <= HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ready_pat[0];
				if ($urandom_range(0, 31) == 0)
					ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				else
					ready_pat <= {ready_pat[0], ready_pat[15:1]};
			end
		end
	end

	always @(posedge clk) begin
		neighbors_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (neighbor_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual left %0d right %0d",
					$time, rsp_ch.left_neighbor, rsp_ch.right_neighbor);
				errors++;
			end else begin
				want = neighbor_q.pop_front();
				if (rsp_ch.left_neighbor !== want.left) begin
					$display("%0t: left_neighbor expected %0d actual %0d",
						$time, want.left, rsp_ch.left_neighbor);
					errors++;
				end
				if (rsp_ch.right_neighbor !== want.right) begin
					$display("%0t: right_neighbor expected %0d actual %0d",
						$time, want.right, rsp_ch.right_neighbor);
					errors++;
				end
			end
		end
	end

endmodule
